// ----- rtl/qof_pkg.sv -----
package qof_pkg;

    localparam int VALUE_W    = 32;
    localparam int FRAC_W     = 17;
    localparam int POS_W      = 12;
    localparam int TOTAL_W    = 13;
    localparam logic [FRAC_W-1:0] FRAC_ONE   = 17'd65536;
    localparam logic [FRAC_W-1:0] FRAC_RESET = 17'd3277;
    localparam logic signed [VALUE_W-1:0] MAG_LIMIT = 32'sd6;
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    typedef struct packed {
        logic                      action;
        logic signed [VALUE_W-1:0] value;
        logic                      present;
        logic                      last_gene;
    } in_item_t;

    typedef struct packed {
        logic [POS_W-1:0]   gene_position;
        logic               flagged;
        logic [TOTAL_W-1:0] flagged_total;
        logic               final_result;
    } out_item_t;

    typedef struct packed {
        logic                      valid;
        logic signed [VALUE_W-1:0] value;
        logic                      present;
        logic                      seal;
        logic [FRAC_W-1:0]         fraction;
    } rank_req_t;

endpackage

// ----- rtl/qof_ranker.sv -----
module qof_ranker
    import qof_pkg::*;
#(
    parameter int MAX_GENES = 4096
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  rank_req_t                 req,
    input  logic                      clear,
    output logic                      busy,
    output logic                      have_present,
    output logic signed [VALUE_W-1:0] upper_cut,
    output logic signed [VALUE_W-1:0] lower_cut
);

    localparam int AW = $clog2(MAX_GENES);
    localparam int CW = $clog2(MAX_GENES + 1);
    localparam int PW = CW + FRAC_W + 1;

    localparam logic [2:0] R_IDLE   = 3'd0;
    localparam logic [2:0] R_CMP    = 3'd1;
    localparam logic [2:0] R_PUT    = 3'd2;
    localparam logic [2:0] R_PICK_U = 3'd3;
    localparam logic [2:0] R_PICK_L = 3'd4;
    localparam logic [2:0] R_END    = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] k_reg, k_next;
    logic signed [VALUE_W-1:0] v_reg, v_next;
    logic seal_reg, seal_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;
    logic signed [VALUE_W-1:0] upper_reg, upper_next, lower_reg, lower_next;

    logic signed [VALUE_W-1:0] mem [MAX_GENES];
    logic signed [VALUE_W-1:0] rd_data;
    logic [AW-1:0] rd_addr, wr_addr;
    logic rd_en, wr_en;
    logic signed [VALUE_W-1:0] wr_data;

    logic [FRAC_W-1:0] q_sel;
    logic [PW-1:0] prod;
    logic [PW-1:0] idx_full;
    logic [AW-1:0] pick_idx;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

    // Order statistic index: round half up, clamped to the last entry.
    assign q_sel    = (state_reg == R_PICK_U) ? (FRAC_ONE - frac_reg) : frac_reg;
    assign prod     = PW'(count_reg) * PW'(q_sel) + PW'(32768);
    assign idx_full = prod >> 16;
    always_comb
    begin
        if (idx_full > PW'(count_reg - 1'b1))
        begin
            pick_idx = AW'(count_reg - 1'b1);
        end
        else
        begin
            pick_idx = idx_full[AW-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        k_next     = k_reg;
        v_next     = v_reg;
        seal_next  = seal_reg;
        frac_next  = frac_reg;
        upper_next = upper_reg;
        lower_next = lower_reg;
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = v_reg;
        case (state_reg)
            R_IDLE:
            begin
                if (clear)
                begin
                    count_next = '0;
                end
                if (req.valid)
                begin
                    v_next    = req.value;
                    seal_next = req.seal;
                    frac_next = (req.fraction > FRAC_ONE) ? FRAC_ONE : req.fraction;
                    if (req.present)
                    begin
                        if (count_reg == '0)
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = '0;
                            wr_data    = req.value;
                            count_next = count_reg + 1'b1;
                            state_next = req.seal ? R_PICK_U : R_IDLE;
                        end
                        else
                        begin
                            k_next     = count_reg;
                            rd_en      = 1'b1;
                            rd_addr    = AW'(count_reg - 1'b1);
                            state_next = R_CMP;
                        end
                    end
                    else if (req.seal)
                    begin
                        state_next = R_PICK_U;
                    end
                end
            end
            R_CMP:
            begin
                wr_en   = 1'b1;
                wr_addr = k_reg[AW-1:0];
                if (rd_data > v_reg)
                begin
                    wr_data = rd_data;
                    k_next  = k_reg - 1'b1;
                    if (k_reg == CW'(1))
                    begin
                        state_next = R_PUT;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = AW'(k_reg - CW'(2));
                    end
                end
                else
                begin
                    wr_data    = v_reg;
                    count_next = count_reg + 1'b1;
                    state_next = seal_reg ? R_PICK_U : R_IDLE;
                end
            end
            R_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = k_reg[AW-1:0];
                wr_data    = v_reg;
                count_next = count_reg + 1'b1;
                state_next = seal_reg ? R_PICK_U : R_IDLE;
            end
            R_PICK_U:
            begin
                if (count_reg == '0)
                begin
                    upper_next = '0;
                    lower_next = '0;
                    state_next = R_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = pick_idx;
                    state_next = R_PICK_L;
                end
            end
            R_PICK_L:
            begin
                upper_next = rd_data;
                rd_en      = 1'b1;
                rd_addr    = pick_idx;
                state_next = R_END;
            end
            R_END:
            begin
                lower_next = rd_data;
                state_next = R_IDLE;
            end
            default:
            begin
                state_next = R_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            count_reg <= '0;
            upper_reg <= '0;
            lower_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            upper_reg <= upper_next;
            lower_reg <= lower_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        v_reg    <= v_next;
        seal_reg <= seal_next;
        frac_reg <= frac_next;
    end

    assign busy         = (state_reg != R_IDLE);
    assign have_present = (count_reg != '0);
    assign upper_cut    = upper_reg;
    assign lower_cut    = lower_reg;

endmodule

// ----- rtl/quantile_outlier_flag.sv -----
// Per-sample outlier flagging by percentile cuts. Load transfers (action 0)
// store one gene each; a present value is insertion-sorted into a sorted
// memory with one read and one write port, which moves each larger entry
// up by one place before the new value is written; the input stalls until
// the insertion is done. The transfer with last_gene set also picks the two
// cuts. Drain transfers (action 1) then return each gene in load order with
// its flag and the running flag count, one per transfer, after a read of the
// value memory. After the final result the block is ready for the next
// sample. The register value is sampled when a sample is sealed; values above
// one saturate.
module quantile_outlier_flag
    import qof_pkg::*;
#(
    parameter int MAX_GENES = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  in_item_t            in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output out_item_t           out_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [FRAC_W-1:0]   cfg_data
);

    localparam int AW = $clog2(MAX_GENES);
    localparam int CW = $clog2(MAX_GENES + 1);

    localparam logic T_IDLE  = 1'b0;
    localparam logic T_DRAIN = 1'b1;

    logic state_reg, state_next;
    logic sealed_reg, sealed_next;
    logic [CW-1:0] loaded_reg, loaded_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] tally_reg, tally_next;
    logic [FRAC_W-1:0] frac_reg;
    logic out_valid_reg, out_valid_next;
    out_item_t out_reg, out_next;

    logic [VALUE_W:0] vmem [MAX_GENES];
    logic [VALUE_W:0] vrd_data;
    logic vwr_en, vrd_en;

    rank_req_t req;
    logic rk_clear, rk_busy, rk_have;
    logic signed [VALUE_W-1:0] upper_cut, lower_cut;

    logic accept;
    logic signed [VALUE_W-1:0] x;
    logic flag, fin;

    qof_ranker #(.MAX_GENES(MAX_GENES)) u_ranker (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .clear        (rk_clear),
        .busy         (rk_busy),
        .have_present (rk_have),
        .upper_cut    (upper_cut),
        .lower_cut    (lower_cut)
    );

    always_ff @(posedge clk)
    begin
        if (vwr_en)
        begin
            vmem[loaded_reg[AW-1:0]] <= {in_item.present, in_item.value};
        end
        if (vrd_en)
        begin
            vrd_data <= vmem[ptr_reg[AW-1:0]];
        end
    end

    assign in_stall  = rk_busy || (state_reg != T_IDLE);
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign x    = vrd_data[VALUE_W-1:0];
    assign flag = vrd_data[VALUE_W] && rk_have &&
                  ((x > upper_cut) ||
                   ((x < lower_cut) && ((x > MAG_LIMIT) || (x < -MAG_LIMIT))));
    assign fin  = (ptr_reg + 1'b1 == loaded_reg);

    always_comb
    begin
        state_next     = state_reg;
        sealed_next    = sealed_reg;
        loaded_next    = loaded_reg;
        ptr_next       = ptr_reg;
        tally_next     = tally_reg;
        out_valid_next = out_valid && out_stall;
        out_next       = out_reg;
        vwr_en         = 1'b0;
        vrd_en         = 1'b0;
        rk_clear       = 1'b0;
        req.valid      = 1'b0;
        req.value      = in_item.value;
        req.present    = 1'b0;
        req.seal       = in_item.last_gene;
        req.fraction   = frac_reg;
        case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    if (in_item.action == ACT_LOAD)
                    begin
                        if (!sealed_reg)
                        begin
                            if (loaded_reg < CW'(MAX_GENES))
                            begin
                                vwr_en      = 1'b1;
                                loaded_next = loaded_reg + 1'b1;
                                req.present = in_item.present;
                            end
                            req.valid   = req.present || in_item.last_gene;
                            sealed_next = in_item.last_gene;
                        end
                    end
                    else if (sealed_reg && (ptr_reg < loaded_reg))
                    begin
                        vrd_en     = 1'b1;
                        state_next = T_DRAIN;
                    end
                end
            end
            T_DRAIN:
            begin
                if (!out_valid || !out_stall)
                begin
                    tally_next             = tally_reg + CW'(flag);
                    out_valid_next         = 1'b1;
                    out_next.gene_position = POS_W'(ptr_reg);
                    out_next.flagged       = flag;
                    out_next.flagged_total = TOTAL_W'(tally_reg + CW'(flag));
                    out_next.final_result  = fin;
                    ptr_next               = ptr_reg + 1'b1;
                    state_next             = T_IDLE;
                    if (fin)
                    begin
                        sealed_next = 1'b0;
                        loaded_next = '0;
                        ptr_next    = '0;
                        tally_next  = '0;
                        rk_clear    = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            sealed_reg    <= 1'b0;
            loaded_reg    <= '0;
            ptr_reg       <= '0;
            tally_reg     <= '0;
            frac_reg      <= FRAC_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sealed_reg    <= sealed_next;
            loaded_reg    <= loaded_next;
            ptr_reg       <= ptr_next;
            tally_reg     <= tally_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                frac_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

// ----- test/tb_top.sv -----
module tb_top;
    import qof_pkg::*;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    in_item_t          in_item = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    out_item_t         out_item;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [FRAC_W-1:0] cfg_data = '0;

    quantile_outlier_flag uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Predictor state for one sample.
    logic [FRAC_W-1:0]         fraction_reg = FRAC_RESET;
    logic signed [VALUE_W-1:0] gene_vals[$];
    logic                      gene_pres[$];
    logic signed [VALUE_W-1:0] ranked[$];
    logic signed [VALUE_W-1:0] upper_cut;
    logic signed [VALUE_W-1:0] lower_cut;
    logic                      sealed = 1'b0;
    int                        drain_idx = 0;
    int                        tally = 0;

    in_item_t  pending_items[$];
    out_item_t expected_results[$];
    int        errors = 0;
    int        results_seen = 0;
    int        samples_done = 0;
    int        cfg_writes = 0;

    function automatic int cut_index(int count, int q);
        longint idx;
        idx = (longint'(count) * q + 32768) >>> 16;
        if (idx > count - 1)
            idx = count - 1;
        return int'(idx);
    endfunction

    task automatic classify_item(in_item_t it);
        int f;
        int k;
        logic signed [VALUE_W-1:0] x;
        longint mag;
        logic flag;
        out_item_t r;
        if (it.action == ACT_LOAD) begin
            if (sealed)
                return;
            if (gene_vals.size() < 4096) begin
                gene_vals.push_back(it.value);
                gene_pres.push_back(it.present);
                if (it.present) begin
                    k = 0;
                    while (k < ranked.size() && ranked[k] <= it.value)
                        k++;
                    ranked.insert(k, it.value);
                end
            end
            if (it.last_gene) begin
                f = (fraction_reg > FRAC_ONE) ? 65536 : int'(fraction_reg);
                sealed = 1'b1;
                drain_idx = 0;
                tally = 0;
                upper_cut = 0;
                lower_cut = 0;
                if (ranked.size() > 0) begin
                    upper_cut = ranked[cut_index(ranked.size(), 65536 - f)];
                    lower_cut = ranked[cut_index(ranked.size(), f)];
                end
            end
            return;
        end
        if (!sealed || drain_idx >= gene_vals.size())
            return;
        x = gene_vals[drain_idx];
        mag = (x < 0) ? -longint'(x) : longint'(x);
        flag = 1'b0;
        if (gene_pres[drain_idx] && ranked.size() > 0) begin
            if (x > upper_cut)
                flag = 1'b1;
            if (x < lower_cut && mag > 6)
                flag = 1'b1;
        end
        if (flag)
            tally++;
        r.gene_position = drain_idx[POS_W-1:0];
        r.flagged = flag;
        r.flagged_total = tally[TOTAL_W-1:0];
        r.final_result = (drain_idx + 1 == gene_vals.size());
        expected_results.push_back(r);
        drain_idx++;
        if (r.final_result) begin
            sealed = 1'b0;
            gene_vals.delete();
            gene_pres.delete();
            ranked.delete();
            drain_idx = 0;
            tally = 0;
        end
    endtask

    // Driver: bursts of transfers separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                classify_item(in_item);
                void'(pending_items.pop_front());
            end
            if (!(in_valid && in_stall)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    in_valid <= 1'b1;
                    in_item <= pending_items[0];
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 20);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall pattern: alternating quiet and busy stretches.
    int stall_phase = 0;
    always @(posedge clk) begin
        stall_phase <= stall_phase + 1;
        if (stall_phase[7])
            out_stall <= ($urandom_range(0, 2) == 0);
        else
            out_stall <= 1'b0;
    end

    // Monitor.
    always @(posedge clk) begin
        out_item_t e;
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $error("unexpected result transfer pos=%0d", out_item.gene_position);
                errors++;
            end else begin
                e = expected_results.pop_front();
                if (e.gene_position !== out_item.gene_position) begin
                    $error("gene_position exp %0d got %0d", e.gene_position,
                           out_item.gene_position);
                    errors++;
                end
                if (e.flagged !== out_item.flagged) begin
                    $error("flagged exp %0d got %0d", e.flagged, out_item.flagged);
                    errors++;
                end
                if (e.flagged_total !== out_item.flagged_total) begin
                    $error("flagged_total exp %0d got %0d", e.flagged_total,
                           out_item.flagged_total);
                    errors++;
                end
                if (e.final_result !== out_item.final_result) begin
                    $error("final_result exp %0d got %0d", e.final_result,
                           out_item.final_result);
                    errors++;
                end
                if (e.final_result)
                    samples_done++;
            end
        end
    end

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $signed($urandom_range(0, 14)) - 7;
            2: return ($urandom_range(0, 1) == 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(0, 200000)) - 100000;
        endcase
    endfunction

    function automatic in_item_t make_item(logic act, logic signed [VALUE_W-1:0] v,
                                           logic pres, logic last);
        in_item_t it;
        it.action = act;
        it.value = v;
        it.present = pres;
        it.last_gene = last;
        return it;
    endfunction

    task automatic queue_sample(int genes, int pres_pct);
        int i;
        for (i = 0; i < genes; i++)
            pending_items.push_back(make_item(ACT_LOAD, pick_value(),
                $urandom_range(0, 99) < pres_pct, i == genes - 1));
        for (i = 0; i < genes; i++)
            pending_items.push_back(make_item(ACT_DRAIN, pick_value(),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
    endtask

    task automatic settle();
        while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_fraction(logic [FRAC_W-1:0] f);
        cfg_valid <= 1'b1;
        cfg_data <= f;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        fraction_reg = f;
        cfg_writes++;
    endtask

    initial begin
        logic [FRAC_W-1:0] fracs[6];
        int total;
        int p;
        int genes;
        fracs = '{17'd0, 17'd65536, 17'h1ffff, 17'd32768, 17'd3277, 17'd1};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // Directed: drain before seal, extremes, absent-only sample, sealed load.
        pending_items.push_back(make_item(ACT_DRAIN, 0, 1'b1, 1'b1));
        pending_items.push_back(make_item(ACT_LOAD, 32'sh7fffffff, 1'b1, 1'b0));
        pending_items.push_back(make_item(ACT_LOAD, 32'sh80000000, 1'b1, 1'b0));
        pending_items.push_back(make_item(ACT_LOAD, 32'sd6, 1'b1, 1'b0));
        pending_items.push_back(make_item(ACT_LOAD, -32'sd7, 1'b1, 1'b0));
        pending_items.push_back(make_item(ACT_LOAD, -32'sd6, 1'b1, 1'b0));
        pending_items.push_back(make_item(ACT_LOAD, 32'sd100, 1'b0, 1'b1));
        pending_items.push_back(make_item(ACT_LOAD, 32'sd5, 1'b1, 1'b1));
        for (p = 0; p < 6; p++)
            pending_items.push_back(make_item(ACT_DRAIN, 0, 1'b0, 1'b0));
        pending_items.push_back(make_item(ACT_LOAD, 32'sd9, 1'b0, 1'b0));
        pending_items.push_back(make_item(ACT_LOAD, -32'sd9, 1'b0, 1'b1));
        pending_items.push_back(make_item(ACT_DRAIN, 0, 1'b0, 1'b0));
        pending_items.push_back(make_item(ACT_DRAIN, -1, 1'b1, 1'b1));
        pending_items.push_back(make_item(ACT_LOAD, 32'sd1, 1'b1, 1'b1));
        pending_items.push_back(make_item(ACT_DRAIN, 0, 1'b0, 1'b0));
        settle();
        total = 20;
        for (p = 0; total < 540; p++) begin
            if (p % 4 == 0) begin
                write_fraction(fracs[(p / 4) % 6]);
                if ((p / 4) >= 6)
                    write_fraction(FRAC_W'($urandom_range(0, 17'h1ffff)));
            end
            if ($urandom_range(0, 9) == 0) begin
                pending_items.push_back(make_item(1'($urandom_range(0, 1)), pick_value(),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
                total++;
            end
            genes = $urandom_range(1, 24);
            queue_sample(genes, $urandom_range(0, 3) == 0 ? 30 : 90);
            total += 2 * genes;
            if (p % 4 == 3)
                settle();
        end
        settle();
        $display("Checked %0d results over %0d samples with %0d register writes.",
                 results_seen, samples_done, cfg_writes);
        if (errors == 0)
            $display("quantile_outlier_flag: match");
        else
            $display("quantile_outlier_flag: mismatch");
        $finish;
    end

    initial begin
        #2000000;
        $display("quantile_outlier_flag: mismatch");
        $finish;
    end

endmodule
